### hdl/assert_macros.svh
// Assertion macros for the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while rst is high.
`define MLFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check on clk that also holds during reset.
`define MLFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/mlfr_pkg.sv
// Types, constants and marker table for the marker/length frame receiver.
`default_nettype none

package mlfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  localparam logic [3:0]  MARKER_LAST  = 4'd9;
  localparam logic [7:0]  MARKER_FIRST = 8'h57;
  localparam logic [1:0]  LEN_LAST     = 2'd3;
  localparam logic [13:0] MAX_PAYLOAD_RESET = 14'd8192;

  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic [12:0] payload_index;
    logic        frame_done;
    logic [13:0] frame_length;
  } mlfr_result_t;

  // "WASMUPDATE"
  function automatic logic [7:0] marker_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = 8'h57;
      4'd1: c = 8'h41;
      4'd2: c = 8'h53;
      4'd3: c = 8'h4D;
      4'd4: c = 8'h55;
      4'd5: c = 8'h50;
      4'd6: c = 8'h44;
      4'd7: c = 8'h41;
      4'd8: c = 8'h54;
      4'd9: c = 8'h45;
      default: c = MARKER_FIRST;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/mlfr_parser.sv
// Frame parser: marker hunt, length assembly and payload indexing, one beat per step.
`default_nettype none
`include "assert_macros.svh"

module mlfr_parser import mlfr_pkg::*; #(
  parameter int BUFFER_BYTES = 8192
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [13:0]  max_payload,
  output mlfr_result_t      res
);

  // max_payload is 14 bits, so a buffer above that never limits.
  localparam int CapInt = (BUFFER_BYTES > 16383) ? 16383 : BUFFER_BYTES;
  localparam logic [13:0] BUF_CAP = 14'(CapInt);

  phase_t      phase, phase_next;
  logic [3:0]  marker_pos, marker_pos_next;
  logic [13:0] len_low, len_low_next;   // length bits 13:0
  logic        len_hi, len_hi_next;     // any of length bits 31:14 set
  logic [1:0]  len_cnt, len_cnt_next;
  logic [13:0] pay_pos, pay_pos_next;

  logic [13:0] limit;
  logic [13:0] merge_low;
  logic        merge_hi;
  logic [13:0] len_low_acc;
  logic        len_hi_acc;
  logic        reject;
  logic [13:0] pay_pos_inc;
  logic        last;

  assign limit = (max_payload > BUF_CAP) ? BUF_CAP : max_payload;

  always_comb begin
    merge_low = '0;
    merge_hi  = 1'b0;
    case (len_cnt)
      2'd0: merge_low[7:0] = rx_byte;
      2'd1: begin
        merge_low[13:8] = rx_byte[5:0];
        merge_hi        = |rx_byte[7:6];
      end
      default: merge_hi = |rx_byte;
    endcase
  end

  assign len_low_acc = len_low | merge_low;
  assign len_hi_acc  = len_hi | merge_hi;
  assign reject      = len_hi_acc || (len_low_acc == '0) || (len_low_acc > limit);
  assign pay_pos_inc = pay_pos + 14'd1;
  assign last        = (pay_pos_inc == len_low);

  // next state
  always_comb begin
    phase_next      = phase;
    marker_pos_next = marker_pos;
    len_low_next    = len_low;
    len_hi_next     = len_hi;
    len_cnt_next    = len_cnt;
    pay_pos_next    = pay_pos;
    case (phase)
      PH_LEN: begin
        len_low_next = len_low_acc;
        len_hi_next  = len_hi_acc;
        len_cnt_next = len_cnt + 2'd1;
        if (len_cnt == LEN_LAST) begin
          if (reject) begin
            phase_next      = PH_HUNT;
            marker_pos_next = '0;
          end else begin
            phase_next   = PH_DATA;
            pay_pos_next = '0;
          end
        end
      end
      PH_DATA: begin
        pay_pos_next = pay_pos_inc;
        if (last) begin
          phase_next      = PH_HUNT;
          marker_pos_next = '0;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (rx_byte == marker_char(marker_pos)) begin
          if (marker_pos == MARKER_LAST) begin
            phase_next      = PH_LEN;
            marker_pos_next = '0;
            len_low_next    = '0;
            len_hi_next     = 1'b0;
            len_cnt_next    = '0;
          end else begin
            marker_pos_next = marker_pos + 4'd1;
          end
        end else begin
          // restart, keeping this byte if it opens a new marker
          marker_pos_next = (rx_byte == MARKER_FIRST) ? 4'd1 : 4'd0;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    res.valid         = (phase == PH_DATA);
    res.payload_byte  = rx_byte;
    res.payload_index = pay_pos[12:0];
    res.frame_done    = (phase == PH_DATA) && last;
    res.frame_length  = ((phase == PH_DATA) && last) ? len_low : 14'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      marker_pos <= '0;
      len_low    <= '0;
      len_hi     <= 1'b0;
      len_cnt    <= '0;
      pay_pos    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      marker_pos <= marker_pos_next;
      len_low    <= len_low_next;
      len_hi     <= len_hi_next;
      len_cnt    <= len_cnt_next;
      pay_pos    <= pay_pos_next;
    end
  end

  `MLFR_ASSERT_ALWAYS(a_marker_pos_range, rst || marker_pos <= MARKER_LAST, "marker position out of range")
  `MLFR_ASSERT(a_pay_pos_below_len, (phase == PH_DATA) |-> (pay_pos < len_low), "payload position past length")
  `MLFR_ASSERT(a_done_to_hunt, (step && res.frame_done) |=> (phase == PH_HUNT && marker_pos == '0), "frame end did not return to hunt")

endmodule

`default_nettype wire

### hdl/marker_length_frame_receiver.sv
// Top level: input register, max_payload register, parser and result register.
// An accepted beat is held in the input register, then passes through the parser into the result register.
// Throughput: one byte per cycle while the result register is empty or being taken;
// the result register advances only then, and the input register also loads whenever it is empty.
// Bytes of marker and length produce no result beat.
// Reset (rst, synchronous): hunt at marker position 0, max_payload = 8192, no beats held.
`default_nettype none

module marker_length_frame_receiver import mlfr_pkg::*; #(
  parameter int BUFFER_BYTES = 8192
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [13:0]  cfg_wr_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   rx_byte,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        payload_byte,
  output logic [12:0]       payload_index,
  output logic              frame_done,
  output logic [13:0]       frame_length
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic [13:0]  max_payload;
  logic         advance;
  logic         step;
  mlfr_result_t res;

  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  mlfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (s1_byte),
    .max_payload (max_payload),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      payload_byte  <= res.payload_byte;
      payload_index <= res.payload_index;
      frame_done    <= res.frame_done;
      frame_length  <= res.frame_length;
    end
  end

endmodule

`default_nettype wire

### test/mlfr_checker.sv
// Checker for the frame receiver: tracks the parser state, predicts payload beats, compares.
module mlfr_checker import mlfr_pkg::*; #(
  parameter logic [79:0] SYNC_WORD = "WASMUPDATE",
  parameter int          BUF_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  payload_byte,
  input  logic [12:0] payload_index,
  input  logic        frame_done,
  input  logic [13:0] frame_length,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYNC_LEN   = 10;
  localparam int SIZE_BYTES = 4;

  typedef struct packed {
    logic [7:0]  data;
    logic [12:0] index;
    logic        done;
    logic [13:0] length;
  } beat_t;

  beat_t       due_beats[$];
  phase_t      parse_phase;
  logic [3:0]  sync_pos;
  logic [31:0] len_acc;
  logic [2:0]  len_cnt;
  logic [31:0] data_pos;
  logic [13:0] cap;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [7:0] sync_char(input int k);
    return SYNC_WORD[8*(SYNC_LEN-1-k) +: 8];
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    logic [31:0] lim;
    beat_t       e;
    case (parse_phase)
      PH_LEN: begin
        lim = (cap > BUF_BYTES) ? 32'(BUF_BYTES) : 32'(cap);
        len_acc = len_acc | (32'(b) << (8 * len_cnt[1:0]));
        len_cnt = len_cnt + 3'd1;
        if (len_cnt >= SIZE_BYTES) begin
          // zero or oversize length: frame dropped without a beat
          if (len_acc == 0 || len_acc > lim) begin
            parse_phase = PH_HUNT;
            sync_pos = '0;
          end else begin
            parse_phase = PH_DATA;
            data_pos = '0;
          end
        end
      end
      PH_DATA: begin
        e.data  = b;
        e.index = data_pos[12:0];
        data_pos = data_pos + 1;
        e.done   = (data_pos >= len_acc);
        e.length = e.done ? len_acc[13:0] : '0;
        due_beats.push_back(e);
        if (e.done) begin
          parse_phase = PH_HUNT;
          sync_pos = '0;
        end
      end
      default: begin
        parse_phase = PH_HUNT;
        if (sync_pos >= SYNC_LEN) sync_pos = '0;
        if (b == sync_char(sync_pos)) begin
          sync_pos = sync_pos + 4'd1;
          if (sync_pos == SYNC_LEN) begin
            parse_phase = PH_LEN;
            sync_pos = '0;
            len_acc = '0;
            len_cnt = '0;
          end
        end else begin
          // a stray first character restarts the match one position in
          sync_pos = (b == sync_char(0)) ? 4'd1 : 4'd0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      parse_phase = PH_HUNT;
      sync_pos = '0;
      len_acc = '0;
      len_cnt = '0;
      data_pos = '0;
      cap = MAX_PAYLOAD_RESET;
      due_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got byte %02h index %0d done %0b len %0d",
                   $time, payload_byte, payload_index, frame_done, frame_length);
          mismatches++;
        end else begin
          want = due_beats.pop_front();
          if (want.data !== payload_byte || want.index !== payload_index ||
              want.done !== frame_done || want.length !== frame_length) begin
            $display("%0t: beat differs, expected byte %02h index %0d done %0b len %0d,%s",
                     $time, want.data, want.index, want.done, want.length,
                     $sformatf(" got byte %02h index %0d done %0b len %0d",
                               payload_byte, payload_index, frame_done, frame_length));
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) cap = cfg_wr_data;
      if (in_valid && in_ready) absorb_byte(rx_byte);
    end
    outstanding = due_beats.size();
  end

endmodule

### test/tb_marker_length_frame_receiver.sv
// Testbench top for the frame receiver: clock, reset, byte stream, config phases and verdict.
module tb_marker_length_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfr_pkg::*;

  localparam int          BUF_BYTES    = 8192;
  localparam logic [79:0] SYNC_WORD    = "WASMUPDATE";
  localparam int          SYNC_LEN     = 10;
  localparam int          NUM_PHASES   = 8;
  localparam int          BIG_PHASE    = 6;
  localparam int          PHASE_BYTES  = 200;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          CYCLE_LIMIT  = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [13:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic [12:0] payload_index;
  logic        frame_done;
  logic [13:0] frame_length;
  int          mismatches;
  int          outstanding;

  logic [13:0] cur_cap = MAX_PAYLOAD_RESET;
  logic        steady_in = 1'b0;
  int          stream_bytes = 0;

  always #6 clk = ~clk;

  marker_length_frame_receiver #(.BUFFER_BYTES(BUF_BYTES)) u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_byte(payload_byte), .payload_index(payload_index),
    .frame_done(frame_done), .frame_length(frame_length)
  );

  mlfr_checker #(.SYNC_WORD(SYNC_WORD), .BUF_BYTES(BUF_BYTES)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_byte(payload_byte), .payload_index(payload_index),
    .frame_done(frame_done), .frame_length(frame_length),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic logic [7:0] sync_char(input int k);
    return SYNC_WORD[8*(SYNC_LEN-1-k) +: 8];
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_limit();
    return (cur_cap > BUF_BYTES) ? BUF_BYTES : int'(cur_cap);
  endfunction

  // one beat on the input channel; returns at the accepting edge
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_sync(input int upto);
    for (int k = 0; k < upto; k++) push_byte(sync_char(k));
    stream_bytes += upto;
  endtask

  task automatic push_word(input logic [31:0] len);
    for (int k = 0; k < 4; k++) push_byte(len[8*k +: 8]);
    stream_bytes += 4;
  endtask

  task automatic push_payload(input int n);
    for (int k = 0; k < n; k++) push_byte(8'($urandom));
    stream_bytes += n;
  endtask

  task automatic run_frame();
    int          lim;
    int          pick;
    int          cut;
    logic [7:0]  b;
    logic [31:0] len;
    steady_in = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        b = ($urandom_range(0, 3) == 0) ? MARKER_FIRST : 8'($urandom);
        push_byte(b);
      end
    end
    // broken marker: partial match, then a wrong character
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, SYNC_LEN - 1);
      push_sync(cut);
      do b = 8'($urandom); while (b == sync_char(cut));
      push_byte(b);
      stream_bytes++;
      return;
    end
    push_sync(SYNC_LEN);
    lim = eff_limit();
    pick = $urandom_range(0, 99);
    if (pick < 60)
      len = (lim == 0) ? 32'd1 : 32'($urandom_range(1, (lim < 40) ? lim : 40));
    else if (pick < 68)
      len = (lim > 0 && lim <= 256) ? 32'(lim) : 32'($urandom_range(1, 8));
    else if (pick < 78)
      len = 32'(lim + 1);
    else if (pick < 86)
      len = '0;
    else
      len = $urandom;
    push_word(len);
    if (len != 0 && len <= lim) push_payload(int'(len));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // marker and length beats may still sit in the pipeline
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_cap(input logic [13:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_cap = v;
  endtask

  // result side: steady, choppy, or held off for a while
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(1, 60);
      repeat (span) begin
        @(negedge clk);
        if (mode < 4)
          out_ready <= 1'b1;
        else if (mode < 9)
          out_ready <= ($urandom_range(0, 3) != 0);
        else
          out_ready <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("marker_length_frame_receiver: mismatch");
    $finish;
  end

  initial begin
    int          ph;
    logic [13:0] next_cap;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // doubled first character, two-byte frame with extreme data, zero length
    push_byte(MARKER_FIRST);
    push_sync(SYNC_LEN);
    push_word(32'd2);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_sync(SYNC_LEN);
    push_word(32'd0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:         next_cap = 14'd1;
          2:         next_cap = 14'h3FFF;
          3:         next_cap = 14'd0;
          4:         next_cap = 14'($urandom_range(2, 48));
          5:         next_cap = 14'($urandom_range(0, 16383));
          BIG_PHASE: next_cap = 14'(BUF_BYTES);
          default:   next_cap = 14'($urandom_range(2, 300));
        endcase
        settle();
        set_cap(next_cap);
      end
      stream_bytes = 0;
      while (stream_bytes < PHASE_BYTES) run_frame();
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("marker_length_frame_receiver: match");
    else
      $display("marker_length_frame_receiver: mismatch");
    $finish;
  end

endmodule
